// ===== src/utf16_to_utf8_transcoder_unit_assert.svh =====
// assertion macros used by the transcoder top-level rtl
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define UTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/utt_pkg.sv =====
package utt_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [20:0] REPL_CP   = 21'h00fffd;
  localparam logic [20:0] SUPP_BASE = 21'h010000;

  localparam logic [7:0] LEAD2 = 8'hc0;
  localparam logic [7:0] LEAD3 = 8'he0;
  localparam logic [7:0] LEAD4 = 8'hf0;
  localparam logic [7:0] CONT  = 8'h80;

  // one queue entry: optional replacement char, then optional code point
  typedef struct packed {
    logic        pre_fffd;
    logic        has_cp;
    logic [20:0] cp;
  } job_t;

  // number of utf-8 bytes minus one
  function automatic logic [1:0] cp_len(input logic [20:0] cp);
    logic [1:0] l;
    if (cp <= 21'h00007f) begin
      l = 2'd0;
    end else if (cp <= 21'h0007ff) begin
      l = 2'd1;
    end else if (cp <= 21'h00ffff) begin
      l = 2'd2;
    end else begin
      l = 2'd3;
    end
    return l;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] lm1,
                                          input logic [1:0] idx);
    logic [7:0] b;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    c0 = CONT | {2'b00, cp[5:0]};
    c1 = CONT | {2'b00, cp[11:6]};
    c2 = CONT | {2'b00, cp[17:12]};
    case (lm1)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: b = (idx == 2'd0) ? (LEAD2 | {3'b000, cp[10:6]}) : c0;
      2'd2: begin
        case (idx)
          2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
          2'd1:    b = c1;
          default: b = c0;
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
          2'd1:    b = c2;
          2'd2:    b = c1;
          default: b = c0;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== src/utt_front.sv =====
module utt_front import utt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [15:0] code_unit,
  input  logic        eos,
  output logic        push,
  output job_t        job
);

  logic [9:0] pend_high_r, pend_high_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic       term_r, term_nxt;
  logic       is_high, is_low;

  assign is_high = code_unit inside {[16'hd800:16'hdbff]};
  assign is_low  = code_unit inside {[16'hdc00:16'hdfff]};

  always_comb begin
    job            = '0;
    pend_high_nxt  = pend_high_r;
    pend_valid_nxt = pend_valid_r;
    term_nxt       = term_r;
    if (!term_r) begin
      if (pend_valid_r && is_low) begin
        job.has_cp     = 1'b1;
        job.cp         = SUPP_BASE + {1'b0, pend_high_r, code_unit[9:0]};
        pend_valid_nxt = 1'b0;
        pend_high_nxt  = '0;
      end else begin
        // unpaired held high surrogate
        job.pre_fffd   = pend_valid_r;
        pend_valid_nxt = 1'b0;
        pend_high_nxt  = '0;
        if (code_unit == 16'h0000) begin
          term_nxt = 1'b1;
        end else if (is_high) begin
          if (eos) begin
            job.has_cp = 1'b1;
            job.cp     = REPL_CP;
          end else begin
            pend_high_nxt  = code_unit[9:0];
            pend_valid_nxt = 1'b1;
          end
        end else if (is_low) begin
          job.has_cp = 1'b1;
          job.cp     = REPL_CP;
        end else begin
          job.has_cp = 1'b1;
          job.cp     = {5'b00000, code_unit};
        end
      end
    end
    if (eos) begin
      pend_valid_nxt = 1'b0;
      pend_high_nxt  = '0;
      term_nxt       = 1'b0;
    end
  end

  assign push = accept && (job.pre_fffd || job.has_cp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_high_r  <= '0;
      pend_valid_r <= 1'b0;
      term_r       <= 1'b0;
    end else if (accept) begin
      pend_high_r  <= pend_high_nxt;
      pend_valid_r <= pend_valid_nxt;
      term_r       <= term_nxt;
    end
  end

endmodule

// ===== src/utt_queue.sv =====
module utt_queue import utt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QDEPTH[QAW:0]);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/utt_back.sv =====
module utt_back import utt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  logic       phase_r;   // 0: replacement prefix, 1: code point
  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic        sel_fffd;
  logic [20:0] cur_cp;
  logic [1:0]  lm1;
  logic [7:0]  cur_byte;
  logic        seg_end, job_end, load;

  assign sel_fffd = head.pre_fffd && !phase_r;
  assign cur_cp   = sel_fffd ? REPL_CP : head.cp;
  assign lm1      = cp_len(cur_cp);
  assign cur_byte = enc_byte(cur_cp, lm1, idx_r);
  assign seg_end  = (idx_r == lm1);
  assign job_end  = seg_end && (!sel_fffd || !head.has_cp);
  assign load     = !q_empty && (!out_valid_r || !out_stall);
  assign pop      = load && job_end;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= job_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        if (job_end) begin
          phase_r <= 1'b0;
          idx_r   <= '0;
        end else if (seg_end) begin
          phase_r <= 1'b1;
          idx_r   <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

// ===== src/utf16_to_utf8_transcoder_unit.sv =====
// utf-16 to utf-8 transcoder: takes one utf-16 code unit per item and emits the utf-8
// bytes one per cycle, while bytes are waiting and out_stall is low, on a byte-wide
// output, with out_last_byte on the final byte an item caused. an item makes one byte
// for ascii, two or three for other bmp units, four for a surrogate pair, and up to
// six when an unpaired high surrogate is flushed as u+fffd ahead of a new unit. items
// that make no bytes (a held high surrogate, a terminating zero and what follows it)
// are not queued. a four-entry queue between the classifier and the byte serializer
// absorbs bursts; when the queue is empty, the first byte of an item passes through
// the queue entry and then the output register before it is on the output.
`include "utf16_to_utf8_transcoder_unit_assert.svh"

module utf16_to_utf8_transcoder_unit import utt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

  logic accept;
  logic q_push, q_pop, q_empty, q_full;
  job_t push_job, head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  utt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .code_unit (in_code_unit),
    .eos       (in_end_of_string),
    .push      (q_push),
    .job       (push_job)
  );

  utt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  utt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  `UTT_ASSERT_IMP(a_no_overflow, q_full, !q_push, "item pushed into a full queue")
  `UTT_ASSERT_NXT(a_pop_last, q_pop, out_valid && out_last_byte, "job retired without last byte")
  `UTT_ASSERT_NXT(a_push_seen, q_push && q_empty, !q_empty, "pushed item lost in queue")

endmodule
